### src/swk_pkg.sv
package swk_pkg;

    localparam int NW           = 4;
    localparam int CORDIC_STEPS = 16;
    localparam int CFG_REGS     = 8;

    localparam int DEG90      = 5760;
    localparam int DEG180     = 11520;
    localparam int DEG360     = 23040;
    localparam int DEG90_FINE = 368640;
    localparam int ONE_Q15    = 32768;
    localparam int ONE_Q20    = 1048576;
    localparam int X0_Q30     = 652032874;

    localparam int SC_XW  = 33;
    localparam int SC_ZW  = 21;
    localparam int VW     = 25;
    localparam int AXW    = 35;
    localparam int AZW    = 22;
    localparam int SQ_BITS = 23;
    localparam int RW     = 48;
    localparam int DIV_BITS = 17;
    localparam int NUMW   = 42;
    localparam int DENW   = 24;

    localparam int SC_LAT    = 18;
    localparam int LANE_LAT  = 4 + SQ_BITS;
    localparam int SCALE_LAT = 4 + DIV_BITS;
    localparam int PIPE_LAT  = SC_LAT + LANE_LAT + SCALE_LAT + 1;

    localparam int ATAN_FINE [CORDIC_STEPS] = '{
        184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    localparam int STOP_ANGLE [NW] = '{2880, 20160, 8640, 14400};
    localparam int OFF_X_RST  [NW] = '{-16384, -16384, 16384, 16384};
    localparam int OFF_Y_RST  [NW] = '{16384, -16384, 16384, -16384};

    typedef struct packed {
        logic                 stop;
        logic                 nz;
        logic [NW-1:0][15:0]  cur;
    } t_side;

endpackage

### src/swk_sincos.sv
module swk_sincos
    import swk_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [15:0]      i_dir,
    output logic signed [SC_XW-1:0] o_cos,
    output logic signed [SC_XW-1:0] o_sin
);

    logic signed [SC_XW-1:0] r_x [0:CORDIC_STEPS];
    logic signed [SC_XW-1:0] r_y [0:CORDIC_STEPS];
    logic signed [SC_ZW-1:0] r_z [0:CORDIC_STEPS];
    logic                    r_neg [0:CORDIC_STEPS];
    logic signed [SC_XW-1:0] r_cos, r_sin;

    logic signed [17:0] w_t0, w_t1, w_t2, w_t3, w_t4;
    logic               w_neg;

    always_comb begin
        w_t0 = 18'(i_dir) + 18'sd5760;
        w_t1 = (w_t0 >= 18'sd11520) ? w_t0 - 18'sd23040 : w_t0;
        w_t2 = (w_t1 >= 18'sd11520) ? w_t1 - 18'sd23040 : w_t1;
        w_t3 = (w_t2 < -18'sd11520) ? w_t2 + 18'sd23040 : w_t2;
        w_t4 = w_t3;
        w_neg = 1'b0;
        if (w_t3 > 18'sd5760) begin
            w_t4 = w_t3 - 18'sd11520;
            w_neg = 1'b1;
        end else if (w_t3 < -18'sd5760) begin
            w_t4 = w_t3 + 18'sd11520;
            w_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= SC_XW'(X0_Q30);
            r_y[0]   <= '0;
            r_z[0]   <= SC_ZW'(w_t4) <<< 6;
            r_neg[0] <= w_neg;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - SC_ZW'(ATAN_FINE[i]);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + SC_ZW'(ATAN_FINE[i]);
                end
                r_neg[i+1] <= r_neg[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
            r_sin <= r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

### src/swk_lane.sv
module swk_lane
    import swk_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [16:0]      i_spd,
    input  logic signed [16:0]      i_rot,
    input  logic signed [SC_XW-1:0] i_cos,
    input  logic signed [SC_XW-1:0] i_sin,
    input  logic signed [16:0]      i_ox,
    input  logic signed [16:0]      i_oy,
    output logic [SQ_BITS-1:0]      o_mag,
    output logic signed [16:0]      o_ang
);

    localparam int ANG_DLY = SQ_BITS - CORDIC_STEPS;

    logic signed [49:0] r_psc, r_pss;
    logic signed [33:0] r_pry, r_prx;
    logic signed [VW-1:0] r_vx, r_vy;
    logic signed [51:0] w_sx, w_sy;
    logic signed [VW-1:0] w_nx, w_ny;
    logic [VW-2:0] w_abx, w_aby;
    logic [2*(VW-1)-1:0] r_ax2, r_ay2;

    logic [RW-1:0]      r_rem  [0:SQ_BITS];
    logic [SQ_BITS-1:0] r_root [0:SQ_BITS];

    logic signed [AXW-1:0] r_cx [0:CORDIC_STEPS];
    logic signed [AXW-1:0] r_cy [0:CORDIC_STEPS];
    logic signed [AZW-1:0] r_cz [0:CORDIC_STEPS];
    logic                  r_zero [0:CORDIC_STEPS];
    logic signed [AXW-1:0] w_px, w_py;
    logic signed [AZW-1:0] w_zr;
    logic signed [16:0]    r_ang_d [0:ANG_DLY];

    always_comb begin
        w_sx  = 52'(r_psc) - (52'(r_pry) <<< 15) + 52'sd16777216;
        w_sy  = 52'(r_pss) + (52'(r_prx) <<< 15) + 52'sd16777216;
        w_nx  = -r_vx;
        w_ny  = -r_vy;
        w_abx = r_vx[VW-1] ? w_nx[VW-2:0] : r_vx[VW-2:0];
        w_aby = r_vy[VW-1] ? w_ny[VW-2:0] : r_vy[VW-2:0];
        w_px  = AXW'(r_vx) <<< 8;
        w_py  = AXW'(r_vy) <<< 8;
        w_zr  = (r_cz[CORDIC_STEPS] + AZW'(32)) >>> 6;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_psc <= i_spd * i_cos;
            r_pss <= i_spd * i_sin;
            r_pry <= i_rot * i_oy;
            r_prx <= i_rot * i_ox;
            r_vx  <= VW'(w_sx >>> 25);
            r_vy  <= VW'(w_sy >>> 25);
            r_ax2 <= w_abx * w_abx;
            r_ay2 <= w_aby * w_aby;
            r_rem[0]  <= RW'(49'(r_ax2) + 49'(r_ay2));
            r_root[0] <= '0;
        end
    end

    for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
        localparam int B = SQ_BITS - 1 - j;
        logic [RW-1:0] w_trial;
        assign w_trial = (RW'(r_root[j]) << (B + 1)) + (RW'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[j] >= w_trial) begin
                    r_rem[j+1]  <= r_rem[j] - w_trial;
                    r_root[j+1] <= r_root[j] | (SQ_BITS'(1) << B);
                end else begin
                    r_rem[j+1]  <= r_rem[j];
                    r_root[j+1] <= r_root[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (r_vx == 0) && (r_vy == 0);
            if (w_px < 0) begin
                if (w_py >= 0) begin
                    r_cx[0] <= w_py;
                    r_cy[0] <= -w_px;
                    r_cz[0] <= AZW'(DEG90_FINE);
                end else begin
                    r_cx[0] <= -w_py;
                    r_cy[0] <= w_px;
                    r_cz[0] <= -AZW'(DEG90_FINE);
                end
            end else begin
                r_cx[0] <= w_px;
                r_cy[0] <= w_py;
                r_cz[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_cy[i] > 0) begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] + AZW'(ATAN_FINE[i]);
                end else begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] - AZW'(ATAN_FINE[i]);
                end
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang_d[0] <= r_zero[CORDIC_STEPS] ? -17'sd5760 : 17'(w_zr) - 17'sd5760;
            for (int j = 1; j <= ANG_DLY; j++) begin
                r_ang_d[j] <= r_ang_d[j-1];
            end
        end
    end

    assign o_mag = r_root[SQ_BITS];
    assign o_ang = r_ang_d[ANG_DLY];

endmodule

### src/swk_scale.sv
module swk_scale
    import swk_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [NW-1:0][SQ_BITS-1:0]   i_mag,
    input  logic [NW-1:0][16:0]          i_ang,
    input  logic [NW-1:0][15:0]          i_cur,
    output logic [NW-1:0][16:0]          o_speed,
    output logic [NW-1:0][15:0]          o_steer
);

    function automatic logic [19:0] wrap_err(input logic signed [19:0] e);
        logic signed [19:0] w;
        w = e;
        if (w > 20'sd11520) begin
            w = w - 20'sd23040;
        end else if (w < -20'sd11520) begin
            w = w + 20'sd23040;
        end
        wrap_err = w[19] ? 20'(-w) : 20'(w);
    endfunction

    logic [SQ_BITS-1:0] r_m01, r_m23, r_max;
    logic [SQ_BITS-1:0] r_mag_a [NW];
    logic [SQ_BITS-1:0] r_mag_b [NW];
    logic [16:0]        r_ang_a [NW];
    logic [16:0]        r_ang_b [NW];

    logic [NUMW-1:0]  r_rem   [0:DIV_BITS][NW];
    logic [16:0]      r_quo   [0:DIV_BITS][NW];
    logic [16:0]      r_small [0:DIV_BITS][NW];
    logic [16:0]      r_ang   [0:DIV_BITS][NW];
    logic [DENW-1:0]  r_den   [0:DIV_BITS];
    logic             r_big   [0:DIV_BITS];

    logic signed [19:0] w_a [NW];
    logic signed [19:0] w_alt [NW];
    logic signed [19:0] w_cur [NW];
    logic [16:0]        w_s [NW];
    logic [NW-1:0][16:0] r_speed;
    logic [NW-1:0][15:0] r_steer;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m01 <= (i_mag[1] > i_mag[0]) ? i_mag[1] : i_mag[0];
            r_m23 <= (i_mag[3] > i_mag[2]) ? i_mag[3] : i_mag[2];
            r_max <= (r_m23 > r_m01) ? r_m23 : r_m01;
            r_den[0] <= {r_max, 1'b0};
            r_big[0] <= r_max > SQ_BITS'(ONE_Q20);
            for (int k = 0; k < NW; k++) begin
                r_mag_a[k] <= i_mag[k];
                r_ang_a[k] <= i_ang[k];
                r_mag_b[k] <= r_mag_a[k];
                r_ang_b[k] <= r_ang_a[k];
                r_rem[0][k]   <= NUMW'({r_mag_b[k], 16'b0}) + NUMW'(r_max);
                r_quo[0][k]   <= '0;
                r_small[0][k] <= 17'((24'(r_mag_b[k]) + 24'd16) >> 5);
                r_ang[0][k]   <= r_ang_b[k];
            end
        end
    end

    for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
        localparam int B = DIV_BITS - 1 - j;
        logic [NUMW-1:0] w_dd;
        assign w_dd = NUMW'(r_den[j]) << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j+1] <= r_den[j];
                r_big[j+1] <= r_big[j];
                for (int k = 0; k < NW; k++) begin
                    r_small[j+1][k] <= r_small[j][k];
                    r_ang[j+1][k]   <= r_ang[j][k];
                    if (r_rem[j][k] >= w_dd) begin
                        r_rem[j+1][k] <= r_rem[j][k] - w_dd;
                        r_quo[j+1][k] <= r_quo[j][k] | (17'd1 << B);
                    end else begin
                        r_rem[j+1][k] <= r_rem[j][k];
                        r_quo[j+1][k] <= r_quo[j][k];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NW; k++) begin
            w_a[k]   = 20'($signed(r_ang[DIV_BITS][k]));
            w_cur[k] = 20'($signed(i_cur[k]));
            w_alt[k] = (w_a[k] + 20'sd11520 > 20'sd23040) ? w_a[k] - 20'sd11520
                                                          : w_a[k] + 20'sd11520;
            w_s[k]   = r_big[DIV_BITS] ? r_quo[DIV_BITS][k] : r_small[DIV_BITS][k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                if (wrap_err(w_a[k] - w_cur[k]) > wrap_err(w_alt[k] - w_cur[k])) begin
                    r_steer[k] <= w_alt[k][15:0];
                    r_speed[k] <= -w_s[k];
                end else begin
                    r_steer[k] <= w_a[k][15:0];
                    r_speed[k] <= w_s[k];
                end
            end
        end
    end

    assign o_speed = r_speed;
    assign o_steer = r_steer;

endmodule

### src/swerve_wheel_kinematics_unit.sv
// Channel   Direction  Signals                          Word
// s_axis    in         i_s_tvalid/o_s_tready            drive command and present angles
// m_axis    out        o_m_tvalid/i_m_tready            wheel speeds and steering angles
// cfg       in         i_cfg_valid/o_cfg_ready          wheel offset register write
//
// A word is accepted every cycle while the output is not stalled.
// The pipeline runs through the sine/cosine CORDIC, the per-wheel square root and the
// scaling divider, all fully pipelined with one stage per step.
// Reset clears the pipeline valid flags and restores the default wheel offsets.
// A stalled output holds the whole pipeline, and the input is not ready meanwhile.
module swerve_wheel_kinematics_unit
    import swk_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // speed_cmd, direction_cmd, rotation_cmd, lf/lr/rf/rr_current_angle
    input  logic [119:0] i_s_tdata,
    // stop_req
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // lf/lr/rf/rr_speed, lf/lr/rf/rr_steer
    output logic [135:0] o_m_tdata,
    // steer_update
    output logic [0:0]   o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [3:0]   i_cfg_index,
    input  logic [16:0]  i_cfg_data
);

    logic w_en;
    logic r_vld [0:PIPE_LAT-1];
    t_side r_side [0:PIPE_LAT-2];
    logic signed [16:0] r_spd_d [0:SC_LAT-1];
    logic signed [16:0] r_rot_d [0:SC_LAT-1];
    logic signed [16:0] r_off_x [NW];
    logic signed [16:0] r_off_y [NW];

    logic signed [16:0] w_spd, w_rot, w_spd_c, w_rot_c;
    logic signed [15:0] w_dir;
    logic               w_nz;
    t_side              w_side;

    logic signed [SC_XW-1:0] w_cos, w_sin;
    logic [NW-1:0][SQ_BITS-1:0] w_mag;
    logic [NW-1:0][16:0]        w_ang;
    logic [NW-1:0][16:0]        w_speed;
    logic [NW-1:0][15:0]        w_steer;

    logic [NW-1:0][16:0] r_out_spd;
    logic [NW-1:0][15:0] r_out_str;
    logic                r_out_upd;

    assign w_en        = !r_vld[PIPE_LAT-1] || i_m_tready;
    assign o_s_tready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_spd = $signed(i_s_tdata[16:0]);
        w_dir = $signed(i_s_tdata[32:17]);
        w_rot = $signed(i_s_tdata[49:33]);
        w_nz  = (w_spd >= -17'sd3) && (w_spd <= 17'sd3) && (w_dir == 16'sd0)
             && (w_rot >= -17'sd3) && (w_rot <= 17'sd3);
        w_spd_c = (w_spd < -17'sd32768) ? -17'sd32768
                : (w_spd > 17'sd32768) ? 17'sd32768 : w_spd;
        w_rot_c = (w_rot < -17'sd32768) ? -17'sd32768
                : (w_rot > 17'sd32768) ? 17'sd32768 : w_rot;
        w_side.stop = i_s_tuser[0];
        w_side.nz   = w_nz;
        for (int k = 0; k < NW; k++) begin
            w_side.cur[k] = i_s_tdata[50 + 16 * k +: 16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW; k++) begin
                r_off_x[k] <= 17'(OFF_X_RST[k]);
                r_off_y[k] <= 17'(OFF_Y_RST[k]);
            end
        end else if (i_cfg_valid && (i_cfg_index < 4'(CFG_REGS))) begin
            if (i_cfg_index[0]) begin
                r_off_y[i_cfg_index[2:1]] <= $signed(i_cfg_data);
            end else begin
                r_off_x[i_cfg_index[2:1]] <= $signed(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PIPE_LAT; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_s_tvalid;
            for (int j = 1; j < PIPE_LAT; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0]  <= w_side;
            r_spd_d[0] <= w_spd_c;
            r_rot_d[0] <= w_rot_c;
            for (int j = 1; j < PIPE_LAT - 1; j++) begin
                r_side[j] <= r_side[j-1];
            end
            for (int j = 1; j < SC_LAT; j++) begin
                r_spd_d[j] <= r_spd_d[j-1];
                r_rot_d[j] <= r_rot_d[j-1];
            end
        end
    end

    swk_sincos u_sincos (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_dir (w_dir),
        .o_cos (w_cos),
        .o_sin (w_sin)
    );

    for (genvar k = 0; k < NW; k++) begin : g_lane
        swk_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_spd (r_spd_d[SC_LAT-1]),
            .i_rot (r_rot_d[SC_LAT-1]),
            .i_cos (w_cos),
            .i_sin (w_sin),
            .i_ox  (r_off_x[k]),
            .i_oy  (r_off_y[k]),
            .o_mag (w_mag[k]),
            .o_ang (w_ang[k])
        );
    end

    swk_scale u_scale (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_mag   (w_mag),
        .i_ang   (w_ang),
        .i_cur   (r_side[PIPE_LAT-3].cur),
        .o_speed (w_speed),
        .o_steer (w_steer)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_side[PIPE_LAT-2].stop) begin
                for (int k = 0; k < NW; k++) begin
                    r_out_spd[k] <= '0;
                    r_out_str[k] <= 16'(STOP_ANGLE[k]);
                end
                r_out_upd <= 1'b1;
            end else if (r_side[PIPE_LAT-2].nz) begin
                r_out_spd <= '0;
                r_out_str <= '0;
                r_out_upd <= 1'b0;
            end else begin
                r_out_spd <= w_speed;
                r_out_str <= w_steer;
                r_out_upd <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_vld[PIPE_LAT-1];
    assign o_m_tdata  = {4'b0, r_out_str, r_out_spd};
    assign o_m_tuser  = r_out_upd;

endmodule
